// ===== src/irpw_pkg.sv =====
`timescale 1ns / 1ps

package irpw_pkg;

	// Input event kinds carried on the input tuser.
	typedef enum logic [1:0] {
		CMD_FALL  = 2'd0,
		CMD_RISE  = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_PARTIAL = 3'd2,
		ST_ADDR    = 3'd3,
		ST_COUNT   = 3'd4,
		ST_CSUM    = 3'd5
	} status_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_OWN_ADDR  = 3'd0;
	localparam logic [2:0] CFG_ZERO_MIN  = 3'd1;
	localparam logic [2:0] CFG_ZERO_MAX  = 3'd2;
	localparam logic [2:0] CFG_ONE_MIN   = 3'd3;
	localparam logic [2:0] CFG_ONE_MAX   = 3'd4;
	localparam logic [2:0] CFG_START_MIN = 3'd5;
	localparam logic [2:0] CFG_START_MAX = 3'd6;
	localparam logic [2:0] CFG_FRAME_GAP = 3'd7;

	// Register reset values.
	localparam logic [7:0]  RST_OWN_ADDR  = 8'd0;
	localparam logic [15:0] RST_ZERO_MIN  = 16'd150;
	localparam logic [15:0] RST_ZERO_MAX  = 16'd500;
	localparam logic [15:0] RST_ONE_MIN   = 16'd550;
	localparam logic [15:0] RST_ONE_MAX   = 16'd900;
	localparam logic [15:0] RST_START_MIN = 16'd2800;
	localparam logic [15:0] RST_START_MAX = 16'd3500;
	localparam logic [19:0] RST_FRAME_GAP = 20'd20000;

	localparam logic [7:0] BCAST_ADDR   = 8'd255;
	localparam logic [5:0] MIN_PROGRESS = 6'd33;
	localparam logic [7:0] MAX_COUNT    = 8'd32;
	localparam int         MIN_BYTES    = 4;

endpackage

// ===== src/ir_pulse_width_frame_receiver.sv =====
`timescale 1ns / 1ps

// Infrared pulse-width frame receiver.
//
// The input stream carries one detector event per transfer: tuser holds the
// kind (falling edge, rising edge, time check) and tdata the 32-bit
// microsecond timestamp. A rising edge measures the armed pulse and, under a
// small sequencer, runs six window compares through one shared subtractor to
// classify it as a zero, a one or a frame start. Bits are packed LSB first
// into a byte memory of FRAME_BYTES entries. A time check past the frame gap
// decodes the frame and emits the payload bytes, or one reject status, on
// the output stream; tlast marks the final result of a decode.
// The block takes one event at a time. A falling edge arms the receiver;
// a rising edge runs one subtract, six compares and one update; a time
// check runs one subtract and the gap compare. A decode adds a check step,
// walks the N stored bytes through the memory read port for the checksum,
// takes a verdict step, then a read and a load step per payload byte.
// The output register decouples the sides: a new event is accepted while the
// last result waits. When the receiver stalls, the sequencer waits at the
// next result until the output register frees. Reset clears control state
// and restores the register defaults; the byte memory needs no clearing.
// Configuration writes are taken in any cycle and always acknowledged.
module ir_pulse_width_frame_receiver #(
	parameter int FRAME_BYTES = 34
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] timestamp
	input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [2:0] status, [10:3] data_byte, [15:11] payload_length
	output logic        m_axis_tuser,   // [0] is_broadcast
	output logic        m_axis_tlast,   // last
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import irpw_pkg::*;

	localparam int AW = $clog2(FRAME_BYTES);
	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_BYTES);
	localparam logic [CW-1:0] MINB_C  = CW'(MIN_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_CMP, S_APPLY, S_GAP, S_CHECK, S_SUM, S_VERDICT,
		S_EMIT_RD, S_EMIT_LD, S_REJ
	} state_t;

	// Configuration registers.
	logic [7:0]  own_addr_q;
	logic [15:0] zero_min_q, zero_max_q, one_min_q, one_max_q;
	logic [15:0] start_min_q, start_max_q;
	logic [19:0] gap_q;

	// Receiver state.
	state_t      state_q;
	logic        armed_q;
	logic [31:0] start_time_q;
	logic [31:0] last_time_q;
	logic [31:0] ts_q;
	logic [31:0] d_q;
	logic [5:0]  prog_q;
	logic [2:0]  bitpos_q;
	logic [CW-1:0] bytepos_q;
	logic [7:0]  cur_byte_q;
	logic [2:0]  step_q;
	logic [5:0]  win_q;

	// Decode state.
	logic [CW-1:0] nb_q;
	logic [CW-1:0] ptr_q;
	logic          rv_s1;
	logic [CW-1:0] ri_s1;
	logic [7:0]    addr_q, cnt_q, sum_q, chk_q;
	status_t       rej_q;

	// Output register.
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [7:0]  out_byte_q;
	logic [4:0]  out_len_q;
	logic        out_bc_q;
	logic        out_last_q;

	// Shared unit and memory hookup.
	logic [31:0] alu_a, alu_b, alu_diff;
	logic        alu_lt;
	logic        mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]  mem_wdata, mem_rdata;

	logic        in_fire, out_free;
	logic        is_zero, is_one, is_start;
	logic [7:0]  new_byte;
	logic [15:0] lo_sel, hi_sel;
	logic [7:0]  nb8;
	logic        addr_ok, cnt_ok;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_byte_q, out_status_q};
	assign m_axis_tuser  = out_bc_q;
	assign m_axis_tlast  = out_last_q;

	// Window bounds for the compare step: pairs of steps cover zero, one, start.
	always_comb begin
		unique case (step_q[2:1])
			2'd0: begin
				lo_sel = zero_min_q;
				hi_sel = zero_max_q;
			end
			2'd1: begin
				lo_sel = one_min_q;
				hi_sel = one_max_q;
			end
			default: begin
				lo_sel = start_min_q;
				hi_sel = start_max_q;
			end
		endcase
	end

	// Operand selection for the shared subtractor.
	always_comb begin
		alu_a = d_q;
		alu_b = d_q;
		case (state_q)
			S_IDLE: begin
				alu_a = s_axis_tdata;
				alu_b = (s_axis_tuser == CMD_RISE) ? start_time_q : last_time_q;
			end
			S_CMP: begin
				if (!step_q[0]) begin
					alu_a = {16'd0, lo_sel};
					alu_b = d_q;
				end else begin
					alu_a = d_q;
					alu_b = {16'd0, hi_sel};
				end
			end
			S_GAP: begin
				alu_a = {12'd0, gap_q};
				alu_b = d_q;
			end
			default: begin
				alu_a = d_q;
				alu_b = d_q;
			end
		endcase
	end

	irpw_sub u_sub (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.lt   (alu_lt)
	);

	// Pulse class, first match wins in the order zero, one, start.
	assign is_zero  = win_q[0] && win_q[1];
	assign is_one   = !is_zero && win_q[2] && win_q[3];
	assign is_start = !is_zero && !is_one && win_q[4] && win_q[5];

	// The byte under assembly is written whole on every bit.
	assign new_byte = (bitpos_q == 3'd0) ? {7'd0, is_one}
	                                     : (cur_byte_q | (8'(is_one) << bitpos_q));

	assign mem_we    = (state_q == S_APPLY) && (prog_q != 6'd0) && (is_zero || is_one)
	                   && (bytepos_q < DEPTH_C);
	assign mem_waddr = bytepos_q[AW-1:0];
	assign mem_wdata = new_byte;
	assign mem_re    = ((state_q == S_SUM) && (ptr_q < nb_q)) || (state_q == S_EMIT_RD);
	assign mem_raddr = ptr_q[AW-1:0];

	irpw_store #(
		.DEPTH (FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign nb8     = 8'(nb_q);
	assign addr_ok = (addr_q == BCAST_ADDR) || (addr_q == own_addr_q);
	assign cnt_ok  = (cnt_q == nb8 - 8'd2) && (cnt_q != 8'd0) && (cnt_q <= MAX_COUNT);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q  <= RST_OWN_ADDR;
			zero_min_q  <= RST_ZERO_MIN;
			zero_max_q  <= RST_ZERO_MAX;
			one_min_q   <= RST_ONE_MIN;
			one_max_q   <= RST_ONE_MAX;
			start_min_q <= RST_START_MIN;
			start_max_q <= RST_START_MAX;
			gap_q       <= RST_FRAME_GAP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OWN_ADDR:  own_addr_q  <= cfg_data[7:0];
				CFG_ZERO_MIN:  zero_min_q  <= cfg_data[15:0];
				CFG_ZERO_MAX:  zero_max_q  <= cfg_data[15:0];
				CFG_ONE_MIN:   one_min_q   <= cfg_data[15:0];
				CFG_ONE_MAX:   one_max_q   <= cfg_data[15:0];
				CFG_START_MIN: start_min_q <= cfg_data[15:0];
				CFG_START_MAX: start_max_q <= cfg_data[15:0];
				CFG_FRAME_GAP: gap_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, receiver state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			armed_q      <= 1'b0;
			start_time_q <= 32'd0;
			last_time_q  <= 32'd0;
			prog_q       <= 6'd0;
			bitpos_q     <= 3'd0;
			bytepos_q    <= '0;
			step_q       <= 3'd0;
			rv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			rv_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						d_q  <= alu_diff;
						ts_q <= s_axis_tdata;
						case (s_axis_tuser)
							CMD_FALL: begin
								armed_q      <= 1'b1;
								start_time_q <= s_axis_tdata;
							end
							CMD_RISE: begin
								if (armed_q) begin
									armed_q <= 1'b0;
									step_q  <= 3'd0;
									state_q <= S_CMP;
								end
							end
							CMD_CHECK: begin
								if (prog_q != 6'd0) begin
									state_q <= S_GAP;
								end
							end
							default: ;
						endcase
					end
				end
				S_CMP: begin
					win_q[step_q] <= alu_lt;
					step_q        <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_IDLE;
					if (prog_q == 6'd0) begin
						if (is_start) begin
							prog_q      <= 6'd1;
							last_time_q <= ts_q;
						end
					end else if (!is_zero && !is_one) begin
						prog_q    <= 6'd0;
						bitpos_q  <= 3'd0;
						bytepos_q <= '0;
					end else begin
						last_time_q <= ts_q;
						cur_byte_q  <= new_byte;
						// Progress only matters up to the minimum length, so it saturates.
						if (prog_q < MIN_PROGRESS) begin
							prog_q <= prog_q + 6'd1;
						end
						bitpos_q <= bitpos_q + 3'd1;
						if (bitpos_q == 3'd7) begin
							if (bytepos_q == DEPTH_C) begin
								// Frame grew past the store: drop it silently.
								prog_q    <= 6'd0;
								bitpos_q  <= 3'd0;
								bytepos_q <= '0;
							end else begin
								bytepos_q <= bytepos_q + CW'(1);
							end
						end
					end
				end
				S_GAP: begin
					state_q <= alu_lt ? S_CHECK : S_IDLE;
				end
				S_CHECK: begin
					nb_q      <= bytepos_q;
					ptr_q     <= '0;
					sum_q     <= 8'd0;
					prog_q    <= 6'd0;
					bitpos_q  <= 3'd0;
					bytepos_q <= '0;
					if (prog_q < MIN_PROGRESS) begin
						rej_q   <= ST_SHORT;
						state_q <= S_REJ;
					end else if (bitpos_q != 3'd0) begin
						rej_q   <= ST_PARTIAL;
						state_q <= S_REJ;
					end else if (bytepos_q < MINB_C) begin
						rej_q   <= ST_SHORT;
						state_q <= S_REJ;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					// Reads are issued one per cycle; data returns in the cycle after the read.
					if (ptr_q < nb_q) begin
						ptr_q <= ptr_q + CW'(1);
					end
					rv_s1 <= (ptr_q < nb_q);
					ri_s1 <= ptr_q;
					if (rv_s1) begin
						if (ri_s1 == CW'(0)) begin
							addr_q <= mem_rdata;
						end
						if (ri_s1 == CW'(1)) begin
							cnt_q <= mem_rdata;
						end
						if (ri_s1 == nb_q - CW'(1)) begin
							chk_q   <= mem_rdata;
							state_q <= S_VERDICT;
						end else begin
							sum_q <= sum_q + mem_rdata;
						end
					end
				end
				S_VERDICT: begin
					ptr_q <= CW'(2);
					if (!addr_ok) begin
						rej_q   <= ST_ADDR;
						state_q <= S_REJ;
					end else if (!cnt_ok) begin
						rej_q   <= ST_COUNT;
						state_q <= S_REJ;
					end else if (sum_q != chk_q) begin
						rej_q   <= ST_CSUM;
						state_q <= S_REJ;
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_OK;
						out_byte_q   <= mem_rdata;
						out_len_q    <= 5'(cnt_q - 8'd1);
						out_bc_q     <= (addr_q == BCAST_ADDR);
						out_last_q   <= (8'(ptr_q) == cnt_q);
						if (8'(ptr_q) == cnt_q) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_q + CW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_REJ: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= rej_q;
						out_byte_q   <= 8'd0;
						out_len_q    <= 5'd0;
						out_bc_q     <= 1'b0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/irpw_sub.sv =====
`timescale 1ns / 1ps

// Shared 32-bit subtractor. It serves the modular time differences, the frame gap
// compare and every window compare, one operation per cycle.
module irpw_sub (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] diff,
	output logic        lt
);
	logic [32:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[31:0];
	assign lt   = full[32];
endmodule

// ===== src/irpw_store.sv =====
`timescale 1ns / 1ps

// Frame byte memory: one write port, one read port with registered data.
module irpw_store #(
	parameter int DEPTH = 34
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== src/irpw_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the result stream.
module irpw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);
	import irpw_pkg::*;

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// A reject is a single, final transfer with empty payload fields.
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK)
		|-> m_axis_tlast && (m_axis_tdata[15:3] == 13'd0) && !m_axis_tuser)
		else $error("malformed reject result");

	// An accepted frame always carries at least one payload byte.
	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == ST_OK) |-> m_axis_tdata[15:11] != 5'd0)
		else $error("payload result without length");
endmodule

bind ir_pulse_width_frame_receiver irpw_checker u_irpw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
